>>> hdl/cau_pkg.sv
// Package with shared types and constants for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DataWidth = 16;
    localparam int FracBits  = 8;
    // Full-precision product and sum widths.
    localparam int ProdWidth = 2 * DataWidth;
    localparam int SumWidth  = ProdWidth + 1;
    // Magnitude width of a sum of two products.
    localparam int MagWidth  = SumWidth;
    // Quotient bits produced by the divider.
    localparam int QuoWidth  = MagWidth + FracBits;
    // Divisor (squared magnitude) width.
    localparam int DenWidth  = ProdWidth + 1;
    // Queue depth between the front and the back.
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        action_t                       action;
        logic                          div_zero;
        logic                          neg_r;
        logic                          neg_i;
        logic [MagWidth-1:0]           mag_r;
        logic [MagWidth-1:0]           mag_i;
        logic [DenWidth-1:0]           den;
    } work_t;

    // Result item.
    typedef struct packed {
        status_t                       status;
        logic signed [DataWidth-1:0]   res_imag;
        logic signed [DataWidth-1:0]   res_real;
    } result_t;

endpackage

>>> hdl/cau_front.sv
// Front end: accepts beats, forms exact products and sums, and classifies each item.
`timescale 1ns / 1ps

module cau_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cau_pkg::action_t                      in_action,
    input  logic signed [cau_pkg::DataWidth-1:0]  in_ar,
    input  logic signed [cau_pkg::DataWidth-1:0]  in_ai,
    input  logic signed [cau_pkg::DataWidth-1:0]  in_br,
    input  logic signed [cau_pkg::DataWidth-1:0]  in_bi,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cau_pkg::work_t                        out_work
);

    localparam int PW = cau_pkg::ProdWidth;
    localparam int SW = cau_pkg::SumWidth;

    // Stage 1: products registered.
    logic                   s1_valid_reg;
    cau_pkg::action_t       s1_action_reg;
    logic signed [PW-1:0]   p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    // Stage 2: classified item registered.
    logic                   s2_valid_reg;
    cau_pkg::work_t         s2_work_reg;
    cau_pkg::work_t         work_next;

    logic adv1, adv2;
    assign adv2     = !s2_valid_reg || out_ready;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    // Multiplier stage: for add/sub the operands pass as products with one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_action_reg <= in_action;
            if (in_action == cau_pkg::ACT_ADD || in_action == cau_pkg::ACT_SUB)
            begin
                // Operand parts carried in the first four product slots.
                p0_reg <= PW'(in_ar);
                p1_reg <= PW'(in_ai);
                p2_reg <= PW'(in_br);
                p3_reg <= PW'(in_bi);
            end
            else
            begin
                p0_reg <= PW'(in_ar * in_br);
                p1_reg <= PW'(in_ai * in_bi);
                p2_reg <= PW'(in_ar * in_bi);
                p3_reg <= PW'(in_ai * in_br);
            end
            p4_reg <= PW'(in_br * in_br);
            p5_reg <= PW'(in_bi * in_bi);
        end
    end

    // Sum and classify.
    logic signed [SW-1:0] sum_r, sum_i;
    always_comb
    begin
        case (s1_action_reg)
            cau_pkg::ACT_ADD:
            begin
                sum_r = SW'(p0_reg) + SW'(p2_reg);
                sum_i = SW'(p1_reg) + SW'(p3_reg);
            end
            cau_pkg::ACT_SUB:
            begin
                sum_r = SW'(p0_reg) - SW'(p2_reg);
                sum_i = SW'(p1_reg) - SW'(p3_reg);
            end
            cau_pkg::ACT_MUL:
            begin
                sum_r = SW'(p0_reg) - SW'(p1_reg);
                sum_i = SW'(p2_reg) + SW'(p3_reg);
            end
            default:
            begin
                sum_r = SW'(p0_reg) + SW'(p1_reg);
                sum_i = SW'(p3_reg) - SW'(p2_reg);
            end
        endcase
        work_next.action   = s1_action_reg;
        work_next.neg_r    = sum_r[SW-1];
        work_next.neg_i    = sum_i[SW-1];
        work_next.mag_r    = sum_r[SW-1] ? cau_pkg::MagWidth'(-sum_r)
                                         : cau_pkg::MagWidth'(sum_r);
        work_next.mag_i    = sum_i[SW-1] ? cau_pkg::MagWidth'(-sum_i)
                                         : cau_pkg::MagWidth'(sum_i);
        work_next.den      = cau_pkg::DenWidth'($unsigned(p4_reg))
                           + cau_pkg::DenWidth'($unsigned(p5_reg));
        work_next.div_zero = (s1_action_reg == cau_pkg::ACT_DIV) && (work_next.den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            s2_work_reg <= work_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_work  = s2_work_reg;

endmodule

>>> hdl/cau_queue.sv
// Short first-in first-out queue between the front and the back.
`timescale 1ns / 1ps

module cau_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  cau_pkg::work_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output cau_pkg::work_t  rd_data
);

    localparam int PW = cau_pkg::QueuePtrW;

    cau_pkg::work_t   slot_reg [cau_pkg::QueueDepth];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != (PW+1)'(cau_pkg::QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/cau_back.sv
// Back end: pipelined restoring divider, rounding, saturation and output register.
`timescale 1ns / 1ps

module cau_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cau_pkg::work_t    in_work,
    output logic              out_valid,
    input  logic              out_ready,
    output cau_pkg::result_t  out_result
);

    localparam int MW = cau_pkg::MagWidth;
    localparam int QW = cau_pkg::QuoWidth;
    localparam int DW = cau_pkg::DenWidth;
    localparam int NW = cau_pkg::DataWidth;
    localparam int FB = cau_pkg::FracBits;
    // One quotient bit per stage.
    localparam int Stages = QW;
    localparam logic [QW-1:0] MaxPos = QW'((64'd1 << (NW - 1)) - 64'd1);

    typedef struct packed {
        cau_pkg::work_t        work;
        logic [QW-1:0]         num_r;
        logic [QW-1:0]         num_i;
        logic [DW:0]           rem_r;
        logic [DW:0]           rem_i;
        logic [QW-1:0]         quo_r;
        logic [QW-1:0]         quo_i;
    } dstage_t;

    logic      stage_valid_reg [Stages+1];
    dstage_t   pipe_reg        [Stages+1];
    dstage_t   pipe_next       [Stages+1];
    logic      adv;
    logic      outv_reg;
    cau_pkg::result_t out_reg;

    assign adv      = !outv_reg || out_ready;
    assign in_ready = adv;

    // Entry of the divider pipeline and one restoring division step per stage,
    // both parts side by side.
    always_comb
    begin
        logic [DW:0] tr, ti;
        logic        ger, gei;
        pipe_next[0].work  = in_work;
        pipe_next[0].num_r = {in_work.mag_r, FB'(0)};
        pipe_next[0].num_i = {in_work.mag_i, FB'(0)};
        pipe_next[0].rem_r = '0;
        pipe_next[0].rem_i = '0;
        pipe_next[0].quo_r = '0;
        pipe_next[0].quo_i = '0;
        for (int s = 0; s < Stages; s++)
        begin
            tr  = {pipe_reg[s].rem_r[DW-1:0], pipe_reg[s].num_r[QW-1]};
            ti  = {pipe_reg[s].rem_i[DW-1:0], pipe_reg[s].num_i[QW-1]};
            ger = (tr >= {1'b0, pipe_reg[s].work.den});
            gei = (ti >= {1'b0, pipe_reg[s].work.den});
            pipe_next[s+1].work  = pipe_reg[s].work;
            pipe_next[s+1].num_r = {pipe_reg[s].num_r[QW-2:0], 1'b0};
            pipe_next[s+1].num_i = {pipe_reg[s].num_i[QW-2:0], 1'b0};
            pipe_next[s+1].rem_r = ger ? (tr - {1'b0, pipe_reg[s].work.den}) : tr;
            pipe_next[s+1].rem_i = gei ? (ti - {1'b0, pipe_reg[s].work.den}) : ti;
            pipe_next[s+1].quo_r = {pipe_reg[s].quo_r[QW-2:0], ger};
            pipe_next[s+1].quo_i = {pipe_reg[s].quo_i[QW-2:0], gei};
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= Stages; s++)
            begin
                stage_valid_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            stage_valid_reg[0] <= in_valid;
            for (int s = 0; s < Stages; s++)
            begin
                stage_valid_reg[s+1] <= stage_valid_reg[s];
            end
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= Stages; s++)
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    // Pick magnitude per action, round, then saturate.
    dstage_t          last;
    logic             last_valid;
    logic [QW-1:0]    mr, mi;
    logic             sat_r, sat_i;
    logic [NW-1:0]    vr, vi;
    cau_pkg::result_t res_next;

    assign last_valid = stage_valid_reg[Stages];

    function automatic logic [QW-1:0] floor_mag(input logic neg, input logic [MW-1:0] mag);
        logic [QW-1:0] r;
        r = QW'(mag >> FB);
        if (neg && (mag & MW'((64'd1 << FB) - 64'd1)) != '0)
        begin
            r = r + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [NW-1:0] clamp(input logic neg, input logic [QW-1:0] mag,
                                            output logic sat);
        logic [NW-1:0] v;
        sat = 1'b0;
        if (neg)
        begin
            if (mag > MaxPos + 1'b1)
            begin
                sat = 1'b1;
                v   = {1'b1, (NW-1)'(0)};
            end
            else
            begin
                v = NW'(-mag);
            end
        end
        else
        begin
            if (mag > MaxPos)
            begin
                sat = 1'b1;
                v   = {1'b0, {(NW-1){1'b1}}};
            end
            else
            begin
                v = NW'(mag);
            end
        end
        return v;
    endfunction

    always_comb
    begin
        last = pipe_reg[Stages];
        case (last.work.action)
            cau_pkg::ACT_MUL:
            begin
                mr = floor_mag(last.work.neg_r, last.work.mag_r);
                mi = floor_mag(last.work.neg_i, last.work.mag_i);
            end
            cau_pkg::ACT_DIV:
            begin
                mr = last.quo_r;
                mi = last.quo_i;
            end
            default:
            begin
                mr = QW'(last.work.mag_r);
                mi = QW'(last.work.mag_i);
            end
        endcase
        vr = clamp(last.work.neg_r, mr, sat_r);
        vi = clamp(last.work.neg_i, mi, sat_i);
        if (last.work.div_zero)
        begin
            res_next.res_real = '0;
            res_next.res_imag = '0;
            res_next.status   = cau_pkg::ST_DIVZ;
        end
        else
        begin
            res_next.res_real = vr;
            res_next.res_imag = vi;
            res_next.status   = (sat_r || sat_i) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outv_reg <= 1'b0;
        end
        else if (adv)
        begin
            outv_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_valid)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid  = outv_reg;
    assign out_result = out_reg;

endmodule

>>> hdl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, queue and back end.
`timescale 1ns / 1ps

// Complex add, subtract, multiply and divide on signed Q8.8 operands. One
// beat is accepted per clock cycle when the output side keeps up; results
// appear in order. A beat passes the front (multiplier and sum registers),
// the four-entry queue and the back: an entry register, a fully pipelined
// restoring divider giving one quotient bit per stage (41 stages) and the
// output register. Every action passes the divider pipeline so results
// stay in order.
module complex_arithmetic_unit_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: a_real[15:0], a_imag[31:16], b_real[47:32], b_imag[63:48]
    input  logic [63:0]  s_axis_tdata,
    // Fields from bit 0: action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: res_real[15:0], res_imag[31:16]
    output logic [31:0]  m_axis_tdata,
    // Fields from bit 0: status[1:0]
    output logic [1:0]   m_axis_tuser
);

    logic              f_valid, f_ready, q_valid, q_ready;
    cau_pkg::work_t    f_work, q_work;
    cau_pkg::result_t  result;

    cau_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (cau_pkg::action_t'(s_axis_tuser)),
        .in_ar     (s_axis_tdata[15:0]),
        .in_ai     (s_axis_tdata[31:16]),
        .in_br     (s_axis_tdata[47:32]),
        .in_bi     (s_axis_tdata[63:48]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_work  (f_work)
    );

    cau_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_work),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_work)
    );

    cau_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_work    (q_work),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.res_imag, result.res_real};
    assign m_axis_tuser = result.status;

endmodule

>>> hdl/cau_checker.sv
// Port-level checker for the complex arithmetic unit and its bind statement.
`timescale 1ns / 1ps

module cau_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [63:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // The reserved status code never appears.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != cau_pkg::ST_RSVD)
        else $error("reserved status");

    // A divide-by-zero status carries a zero result.
    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == cau_pkg::ST_DIVZ |-> m_axis_tdata == 32'd0)
        else $error("divide by zero with nonzero result");

    // Nothing comes out in the cycle after reset.
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> sim/complex_arithmetic_unit_core_test.sv
// Self-checking testbench for the complex arithmetic unit core.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_test;

    // One stimulus row: operation, operands and an optional typed-in result.
    typedef struct {
        cau_pkg::action_t act;
        logic [15:0]      ar;
        logic [15:0]      ai;
        logic [15:0]      br;
        logic [15:0]      bi;
        bit               fixed;
        logic [15:0]      xr;
        logic [15:0]      xi;
        cau_pkg::status_t xs;
    } row_t;

    typedef struct packed {
        cau_pkg::status_t status;
        logic [15:0]      res_imag;
        logic [15:0]      res_real;
    } answer_t;

    localparam int RandomBeats = 1800;
    localparam int DrainCycles = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    answer_t pending_answers[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_idle_pct;
    row_t    directed_rows[$];

    complex_arithmetic_unit_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Clamp an exact value to 16 bits, flagging saturation.
    function automatic logic [15:0] clamp16(input logic signed [79:0] v, inout bit sat);
        if (v > 80'sd32767)
        begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (v < -80'sd32768)
        begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Quotient truncated toward zero of num * 256 / den, with the magnitude capped at 2^40.
    function automatic logic signed [79:0] scaled_quotient(input logic signed [79:0] num,
                                                          input logic signed [79:0] den);
        logic signed [79:0] mag;
        logic signed [79:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< 8) / den;
        if (q > (80'sd1 <<< 40))
            q = 80'sd1 <<< 40;
        return (num < 0) ? -q : q;
    endfunction

    // Work out the expected result of one beat.
    function automatic answer_t complex_result(input cau_pkg::action_t act,
                                               input logic [15:0] ar_u,
                                               input logic [15:0] ai_u, input logic [15:0] br_u,
                                               input logic [15:0] bi_u);
        logic signed [79:0] ar, ai, br, bi, vr, vi, den;
        answer_t ans;
        bit sat;
        ar = $signed(ar_u);
        ai = $signed(ai_u);
        br = $signed(br_u);
        bi = $signed(bi_u);
        sat = 1'b0;
        case (act)
            cau_pkg::ACT_ADD:
            begin
                vr = ar + br;
                vi = ai + bi;
            end
            cau_pkg::ACT_SUB:
            begin
                vr = ar - br;
                vi = ai - bi;
            end
            cau_pkg::ACT_MUL:
            begin
                vr = (ar * br - ai * bi) >>> 8;
                vi = (ar * bi + ai * br) >>> 8;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    ans.res_real = '0;
                    ans.res_imag = '0;
                    ans.status   = cau_pkg::ST_DIVZ;
                    return ans;
                end
                vr = scaled_quotient(ar * br + ai * bi, den);
                vi = scaled_quotient(ai * br - ar * bi, den);
            end
        endcase
        ans.res_real = clamp16(vr, sat);
        ans.res_imag = clamp16(vi, sat);
        ans.status   = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        return ans;
    endfunction

    // Offer one beat, with random idle cycles before it, and log its expectation.
    task automatic send_beat(input row_t r);
        answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.bi, r.br, r.ai, r.ar};
        s_axis_tuser  <= r.act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (r.fixed)
        begin
            ans.res_real = r.xr;
            ans.res_imag = r.xi;
            ans.status   = r.xs;
        end
        else
            ans = complex_result(r.act, r.ar, r.ai, r.br, r.bi);
        pending_answers.push_back(ans);
        @(negedge clk);
    endtask

    // Random operand: wide random half the time, otherwise an extreme or a small value.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3, 4: return 16'($signed($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic row_t random_row();
        row_t r;
        r.act   = cau_pkg::action_t'($urandom_range(3));
        r.ar    = pick_operand();
        r.ai    = pick_operand();
        r.br    = pick_operand();
        r.bi    = pick_operand();
        if ($urandom_range(19) == 0)
        begin
            r.br = '0;
            r.bi = '0;
        end
        r.fixed = 1'b0;
        return r;
    endfunction

    function automatic row_t mk(input cau_pkg::action_t act, input logic [15:0] ar,
                                input logic [15:0] ai,
                                input logic [15:0] br, input logic [15:0] bi, input bit fixed,
                                input logic [15:0] xr, input logic [15:0] xi,
                                input cau_pkg::status_t xs);
        row_t r;
        r = '{act, ar, ai, br, bi, fixed, xr, xi, xs};
        return r;
    endfunction

    // Receiver: random stalls and an in-order comparison against the oldest expectation.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat data=%h user=%h", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[15:0] !== want.res_real || m_axis_tdata[31:16] !== want.res_imag
                    || m_axis_tuser !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                                 want.res_real, want.res_imag, want.status,
                                 m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        int waited;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = cau_pkg::ACT_ADD;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: extremes, each operation, saturation and divide by zero.
        directed_rows.push_back(mk(cau_pkg::ACT_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
                                   16'h0000, 16'h0000, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1,
                                   16'h7fff, 16'h8000, cau_pkg::ST_SAT));
        directed_rows.push_back(mk(cau_pkg::ACT_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1,
                                   16'hffff, 16'hffff, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1,
                                   16'h8000, 16'h7fff, cau_pkg::ST_SAT));
        directed_rows.push_back(mk(cau_pkg::ACT_SUB, 16'h0100, 16'h0200, 16'h0100, 16'h0200, 1,
                                   16'h0000, 16'h0000, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
                                   16'h0100, 16'h0000, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1,
                                   16'h0000, 16'h7fff, cau_pkg::ST_SAT));
        directed_rows.push_back(mk(cau_pkg::ACT_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 0,
                                   0, 0, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 0,
                                   0, 0, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000, 1,
                                   16'h0000, 16'h0000, cau_pkg::ST_DIVZ));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
                                   16'h0100, 16'h0000, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1,
                                   16'h7fff, 16'h7fff, cau_pkg::ST_SAT));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000, 1,
                                   16'h8000, 16'h8000, cau_pkg::ST_SAT));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'hffff, 16'h0001, 16'h0300, 16'hfd00, 0,
                                   0, 0, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0,
                                   0, 0, cau_pkg::ST_OK));
        directed_rows.push_back(mk(cau_pkg::ACT_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff, 0,
                                   0, 0, cau_pkg::ST_OK));
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        // Let everything drain before the random part.
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);

        // Random beats in three idling phases.
        for (int n = 0; n < RandomBeats; n++)
        begin
            if (n == RandomBeats / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 28;
            end
            else if (n == 2 * RandomBeats / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (n == 0)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 49;
            end
            send_beat(random_row());
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow extra cycles for any stray beat.
        while (pending_answers.size() != 0)
            @(negedge clk);
        waited = 0;
        while (waited < DrainCycles)
        begin
            @(negedge clk);
            waited++;
        end
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_queue.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit_core.sv
hdl/cau_checker.sv
sim/complex_arithmetic_unit_core_test.sv
